// ----- hw/rtl/gelu_tanh_activation_top_assert.svh -----
// ---------------------------------------------------------------------------
// gelu_tanh_activation_top_assert.svh
// Assertion macros shared by the GeLU activation block.
// ---------------------------------------------------------------------------
`ifndef GELU_TANH_ACTIVATION_TOP_ASSERT_SVH
`define GELU_TANH_ACTIVATION_TOP_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define GTA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define GTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gta_pkg.sv -----
// ---------------------------------------------------------------------------
// gta_pkg
// Types, constants and the sigmoid table of the GeLU activation block.
// ---------------------------------------------------------------------------
package gta_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned FracW    = 10;
  localparam int unsigned TblBits  = 8;
  localparam int unsigned TblN     = (1 << TblBits) + 1;
  localparam int unsigned SegShift = 28 - TblBits;
  localparam int unsigned TblW     = 31;

  localparam int unsigned A24W   = 27;
  localparam int unsigned A2W    = 30;
  localparam int unsigned InnerW = 28;
  localparam int unsigned U24W   = 31;

  localparam logic [24:0] C1 = 25'd26772563;
  localparam logic [20:0] C3 = 21'd1197135;
  localparam logic [TblW-1:0] OneQ30 = TblW'(1 << 30);

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    last;
  } gta_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] activation;
    logic                    last_out;
  } gta_out_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [DataW-1:0] mag;
    logic             last;
  } gta_cls_t;

  typedef struct packed {
    logic [1:0] count;
  } gta_q_status_t;

  typedef logic [TblW-1:0] gta_tbl_t [TblN];

  // Unsigned shift-and-subtract division, used only while building the table.
  function automatic logic [63:0] gta_udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid(16*k/2^TblBits) in Q30, built at elaboration.
  function automatic gta_tbl_t gta_build_table();
    gta_tbl_t    tbl;
    logic [63:0] t;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] e;
    logic [63:0] d;
    for (int k = 0; k < TblN; k++) begin
      t    = 64'(k) << (27 - TblBits);
      term = 64'd1 << 31;
      sum  = 64'sd1 <<< 31;
      for (int i = 1; i <= 5; i++) begin
        term = gta_udiv64((term * t) >> 31, 64'(i));
        if (i[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      e = $unsigned(sum);
      if (e > (64'd1 << 31)) begin
        e = 64'd1 << 31;
      end
      for (int i = 0; i < 8; i++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      d = (64'd1 << 31) + e;
      tbl[k] = TblW'(gta_udiv64((64'd1 << 61) + (d >> 1), d));
    end
    return tbl;
  endfunction

  localparam gta_tbl_t SigTable = gta_build_table();

endpackage

// ----- hw/rtl/gta_front.sv -----
// ---------------------------------------------------------------------------
// gta_front
// Accepts input words, splits sign and magnitude and flags large inputs.
// ---------------------------------------------------------------------------
module gta_front import gta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gta_in_t  in_data_i,
  output logic     cls_valid_o,
  input  logic     cls_ready_i,
  output gta_cls_t cls_data_o
);

  logic     valid_q;
  gta_cls_t cls_q, cls_d;
  logic [DataW-1:0] raw;

  assign raw        = in_data_i.sample;
  assign in_ready_o = !valid_q || cls_ready_i;

  always_comb begin
    cls_d.neg  = raw[DataW-1];
    cls_d.mag  = raw[DataW-1] ? (~raw + 1'b1) : raw;
    // Magnitudes of eight or more saturate the sigmoid to one.
    cls_d.big  = (cls_d.mag >= DataW'(8 << FracW));
    cls_d.last = in_data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = valid_q;
  assign cls_data_o  = cls_q;

endmodule

// ----- hw/rtl/gta_queue.sv -----
// ---------------------------------------------------------------------------
// gta_queue
// Two-entry queue between the front and the back.
// ---------------------------------------------------------------------------
module gta_queue import gta_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gta_cls_t      push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output gta_cls_t      pop_data_o,
  output gta_q_status_t status_o
);

  gta_cls_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];
  assign status_o.count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/gta_back.sv -----
// ---------------------------------------------------------------------------
// gta_back
// Arithmetic pipeline: argument, interpolated sigmoid, product and rounding.
// ---------------------------------------------------------------------------
module gta_back import gta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gta_cls_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gta_out_t out_data_o
);

  localparam int unsigned NStg = 6;

  logic              adv;
  logic [NStg:1]     v_q;
  gta_cls_t          w_q [NStg:1];
  logic [A24W-1:0]   a24_q [2:1];
  logic [A2W-1:0]    a2_q;
  logic [InnerW-1:0] inner_q;
  logic [U24W-1:0]   u24_q;
  logic [TblW-1:0]   lo_q, dif_q;
  logic              up_q, sat_q;
  logic [SegShift-1:0] f_q;
  logic [TblW-1:0]   s_q;
  logic [DataW+TblW-1:0] p_q;
  logic              out_valid_q;
  gta_out_t          out_q;

  logic [A24W-1:0]   a24_d;
  logic [2*A24W-1:0] sq;
  logic [20+A2W:0]   c3p;
  logic [A24W+InnerW-1:0] up_prod;
  logic [TblBits:0]  idx;
  logic [TblW-1:0]   lo, hi;
  logic [TblW+SegShift-1:0] dprod;
  logic [TblW-1:0]   q, s_d;
  logic [DataW+TblW-1:0] rsum;
  logic [DataW:0]    r, lim;
  logic [DataW-1:0]  rs;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign a24_d   = {in_data_i.mag[FracW+2:0], (24 - FracW)'(0)};
  assign sq      = a24_d * a24_d;
  assign c3p     = C3 * a2_q;
  assign up_prod = a24_q[2] * inner_q;
  assign idx     = {1'b0, u24_q[SegShift+TblBits-1:SegShift]};
  assign lo      = SigTable[idx];
  assign hi      = SigTable[idx + (TblBits+1)'(1)];
  assign dprod   = dif_q * f_q;
  assign q       = dprod[TblW+SegShift-1:SegShift];

  always_comb begin
    if (sat_q) begin
      s_d = OneQ30;
    end else if (up_q) begin
      s_d = lo_q + q;
    end else begin
      s_d = lo_q - q;
    end
    if (w_q[4].neg) begin
      s_d = OneQ30 - s_d;
    end
  end

  // Round half away from zero on the magnitude, then saturate and re-sign.
  always_comb begin
    rsum = p_q + (DataW+TblW)'(1 << 29);
    r    = rsum[DataW+TblW-1:30];
    lim  = w_q[6].neg ? (DataW+1)'(1 << (DataW-1)) : (DataW+1)'((1 << (DataW-1)) - 1);
    if (r > lim) begin
      r = lim;
    end
    rs = w_q[6].neg ? (~r[DataW-1:0] + 1'b1) : r[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[NStg-1:1], in_valid_i};
      out_valid_q <= v_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q[1]   <= in_data_i;
      a24_q[1] <= a24_d;
      a2_q     <= sq[2*A24W-1:24];
      for (int k = 2; k <= NStg; k++) begin
        w_q[k] <= w_q[k-1];
      end
      a24_q[2] <= a24_q[1];
      inner_q  <= InnerW'(C1) + InnerW'(c3p[20+A2W:24]);
      u24_q    <= up_prod[A24W+InnerW-1:24];
      up_q     <= (hi >= lo);
      lo_q     <= lo;
      dif_q    <= (hi >= lo) ? (hi - lo) : (lo - hi);
      f_q      <= u24_q[SegShift-1:0];
      sat_q    <= w_q[3].big || (u24_q[U24W-1:SegShift+TblBits] != '0);
      s_q      <= s_d;
      p_q      <= w_q[5].mag * s_q;
      out_q.activation <= rs;
      out_q.last_out   <= w_q[6].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/gelu_tanh_activation_top.sv -----
// ---------------------------------------------------------------------------
// gelu_tanh_activation_top
// Elementwise tanh-approximated GeLU on Q5.10 samples.
// ---------------------------------------------------------------------------
// The block takes one word per clock when nothing stalls and returns one
// word per input word, in order, with the last flag copied through. Each
// word computes z * sigmoid(2*sqrt(2/pi)*z*(1+0.044715*z^2)) in fixed
// point; the sigmoid comes from a 257-entry constant table with linear
// interpolation, and the final product is rounded half away from zero and
// saturated. Throughput is one word per cycle when nothing stalls. An
// accepted word passes the front register, the queue and the back
// pipeline, whose stages hold the three chained multiplies, the table
// read, the interpolation multiply, the final product and the rounded
// output. The two-entry queue lets the front keep accepting while the
// output side stalls, until the queue and the front register fill.
module gelu_tanh_activation_top import gta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gta_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gta_out_t out_data_o
);

  `include "gelu_tanh_activation_top_assert.svh"

  // Front to queue.
  logic          cls_valid, cls_ready;
  gta_cls_t      cls_data;
  // Queue to back.
  logic          q_valid, q_ready;
  gta_cls_t      q_data;
  gta_q_status_t q_status;

  gta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cls_valid_o (cls_valid),
    .cls_ready_i (cls_ready),
    .cls_data_o  (cls_data)
  );

  gta_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cls_valid),
    .push_ready_o (cls_ready),
    .push_data_i  (cls_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data),
    .status_o     (q_status)
  );

  gta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The queue never holds more than its two entries.
  `GTA_ASSERT_IMPL(a_queue_bound, 1'b1, q_status.count <= 2'd2, "queue overflow")

  // A full queue with no pop stays full in the next cycle.
  `GTA_ASSERT_NEXT(a_queue_hold, q_status.count == 2'd2 && !q_ready, q_status.count == 2'd2, "queue lost an entry")

  // GeLU of a negative input is small: negative results stay above -0.25.
  `GTA_ASSERT_IMPL(a_neg_bound, out_valid_o && out_data_o.activation[DataW-1], $signed(out_data_o.activation) > -(DataW'(1) <<< (FracW-2)), "negative result out of range")

endmodule

// ----- tb/gta_checker.sv -----
// ---------------------------------------------------------------------------
// gta_checker
// Watches both channels, predicts each GeLU word and compares it field by field.
// ---------------------------------------------------------------------------
module gta_checker import gta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  gta_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  gta_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] sig_q30 [TblN];
  gta_out_t    gelu_expected_q[$];

  // Sigmoid table in Q30, built independently of the package.
  function automatic logic [63:0] exp_neg_q31(int k);
    logic [63:0] t;
    logic [63:0] term;
    longint      acc;
    logic [63:0] e;
    t    = 64'(k) << (27 - TblBits);
    term = 64'd1 << 31;
    acc  = longint'(64'd1 << 31);
    for (int i = 1; i <= 5; i++) begin
      term = ((term * t) >> 31) / 64'(i);
      if (i % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    e = 64'(acc);
    if (e > (64'd1 << 31)) e = 64'd1 << 31;
    for (int i = 0; i < 8; i++) e = (e * e + (64'd1 << 30)) >> 31;
    return e;
  endfunction

  function automatic gta_out_t gelu_predict(gta_in_t w);
    logic [63:0] raw, mag, s, a24, a2, inner, u24, idx, f, lo, hi, r, lim;
    logic        neg;
    gta_out_t    o;
    raw = 64'(w.sample) & 64'hffff;
    neg = raw[15];
    mag = neg ? ((~raw + 1) & 64'hffff) : raw;
    if (mag >= (64'd8 << FracW)) begin
      s = 64'd1 << 30;
    end else begin
      a24   = mag << (24 - FracW);
      a2    = (a24 * a24) >> 24;
      inner = 64'd26772563 + ((64'd1197135 * a2) >> 24);
      u24   = (a24 * inner) >> 24;
      if (u24 >= (64'd16 << 24)) begin
        s = 64'd1 << 30;
      end else begin
        idx = u24 >> SegShift;
        f   = u24 & ((64'd1 << SegShift) - 1);
        if (idx >= TblN - 1) begin
          s = sig_q30[TblN-1];
        end else begin
          lo = sig_q30[idx];
          hi = sig_q30[idx+1];
          if (hi >= lo) s = lo + (((hi - lo) * f) >> SegShift);
          else s = lo - (((lo - hi) * f) >> SegShift);
        end
      end
    end
    if (neg) s = (64'd1 << 30) - s;
    r   = (mag * s + (64'd1 << 29)) >> 30;
    lim = neg ? 64'd32768 : 64'd32767;
    if (r > lim) r = lim;
    o.activation = neg ? 16'(~r + 1) : 16'(r);
    o.last_out   = w.last;
    return o;
  endfunction

  initial begin
    logic [63:0] d;
    for (int k = 0; k < TblN; k++) begin
      d = (64'd1 << 31) + exp_neg_q31(k);
      sig_q30[k] = ((64'd1 << 61) + (d >> 1)) / d;
    end
    fail_count_o = 0;
  end

  assign pending_o = gelu_expected_q.size();

  always @(posedge clk_i) begin
    gta_out_t want;
    int       errs;
    errs = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) gelu_expected_q.push_back(gelu_predict(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (gelu_expected_q.size() == 0) begin
          $error("activation: expected no word, actual %0d",
                 $signed(out_data_i.activation));
          errs = errs + 1;
        end else begin
          want = gelu_expected_q.pop_front();
          if (want.activation !== out_data_i.activation) begin
            $error("activation: expected %0d, actual %0d", $signed(want.activation),
                   $signed(out_data_i.activation));
            errs = errs + 1;
          end
          if (want.last_out !== out_data_i.last_out) begin
            $error("last_out: expected %0b, actual %0b", want.last_out,
                   out_data_i.last_out);
            errs = errs + 1;
          end
        end
      end
    end
    if (errs != 0) fail_count_o <= fail_count_o + errs;
  end
endmodule

// ----- tb/tb_gelu_tanh_activation_top.sv -----
// ---------------------------------------------------------------------------
// tb_gelu_tanh_activation_top
// Directed and random stimulus for the GeLU block under random backpressure.
// ---------------------------------------------------------------------------
module tb_gelu_tanh_activation_top import gta_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  gta_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  gta_out_t out_data_o;
  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  bit       hold_off_done = 1'b0;

  localparam int CycleLimit = 400000;

  gelu_tanh_activation_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  gta_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The cycle counter is the only guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offers one word and holds it steady until the block takes it.
  task automatic send_word(logic signed [15:0] z, logic lst);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.sample <= z;
    in_data_i.last <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random samples weighted toward the interesting region below magnitude eight.
  function automatic logic [15:0] rand_sample();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 16'($signed($urandom_range(16383)) - 8192);
    if (p < 75) return 16'($signed($urandom_range(2047)) - 1024);
    return 16'($urandom());
  endfunction

  // Receiver: random stalls, plus one long hold-off counted in cycles.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_off_done && cycle_count > 3000) begin
        out_ready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_off_done = 1'b1;
      end
      gap = gap_len();
      if (gap > 0 && $urandom_range(3) == 0 && cycle_count < 1200 ||
          gap > 0 && cycle_count >= 1200) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic signed [15:0] directed [$];
    directed = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh0001, -16'sh0001,
                 16'sh2000, -16'sh2000, 16'sh1fff, -16'sh1fff, 16'sh0400,
                 -16'sh0400, 16'sh0c00, -16'sh0c00, 16'sh0200, -16'sh0200,
                 16'sh5555, 16'shaaaa, 16'sh1000, -16'sh1000, 16'sh0a00};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_word(directed[i], i[0]);
    for (int n = 0; n < 1950; n++) begin
      send_word(rand_sample(), $urandom_range(7) == 0);
      // One pause with nothing in flight, so the block drains completely.
      if (n == 900) begin
        in_valid_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
